>>> rtl/core/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Define ASSERT_OFF to compile all checks out.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define QTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte assertion failed");
// Next-cycle implication
`define QTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte assertion failed");
`else
`define QTE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QTE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN  = 24;
  localparam int SQ_STAGES = 29;   // root bits of a 2^56 radicand

  localparam int PW   = 34;        // sine of pitch, Q2.28 times two
  localparam int AW   = 33;        // atan2 arguments
  localparam int S_W  = 30;        // clamped sine
  localparam int V_W  = 58;        // square root radicand and root
  localparam int CW   = 37;        // CORDIC x / y
  localparam int ANG_W = 26;       // angle, degrees Q.16

  localparam logic signed [AW-1:0]  HALF_Q28 = AW'(134217728);
  localparam logic signed [PW-1:0]  ONE_Q28  = PW'(268435456);
  localparam logic [V_W-1:0]        ONE_SQ   = V_W'(1) << 56;
  localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(5898240);
  localparam logic signed [15:0]    LIM_180 = 16'sd23040;
  localparam logic signed [15:0]    LIM_90  = 16'sd11520;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;
  } lane_t;

  typedef struct packed {
    logic signed [AW-1:0]  hy;
    logic signed [AW-1:0]  hx;
    logic signed [AW-1:0]  by;
    logic signed [AW-1:0]  bx;
    logic signed [S_W-1:0] s;
    logic                  lock;
    logic                  sp_pos;
  } side_t;

  // atan(2^-i) in degrees Q.16, rounded
  function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0: a = ANG_W'(2949120);
      1: a = ANG_W'(1740967);
      2: a = ANG_W'(919879);
      3: a = ANG_W'(466945);
      4: a = ANG_W'(234379);
      5: a = ANG_W'(117304);
      6: a = ANG_W'(58666);
      7: a = ANG_W'(29335);
      8: a = ANG_W'(14668);
      9: a = ANG_W'(7334);
      10: a = ANG_W'(3667);
      11: a = ANG_W'(1833);
      12: a = ANG_W'(917);
      13: a = ANG_W'(458);
      14: a = ANG_W'(229);
      15: a = ANG_W'(115);
      16: a = ANG_W'(57);
      17: a = ANG_W'(29);
      18: a = ANG_W'(14);
      19: a = ANG_W'(7);
      20: a = ANG_W'(4);
      21: a = ANG_W'(2);
      22: a = ANG_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Quadrant fold into the right half plane before the CORDIC stages
  function automatic lane_t prerot(input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.ang = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.ang = ANG_90;
        l.x = y;
        l.y = -x;
      end else begin
        l.ang = -ANG_90;
        l.x = -y;
        l.y = x;
      end
    end
    return l;
  endfunction

  // Round Q.16 degrees to Q8.7 and saturate
  function automatic logic signed [15:0] to_q7(input logic signed [ANG_W-1:0] ang,
                                               input logic signed [15:0] lim);
    logic signed [ANG_W-1:0] sum;
    logic signed [ANG_W-10:0] r;
    logic signed [15:0] q;
    sum = ang + ANG_W'(256);
    r = $signed(sum[ANG_W-1:9]);
    if (r > lim) begin
      q = lim;
    end else if (r < -lim) begin
      q = -lim;
    end else begin
      q = 16'(r);
    end
    return q;
  endfunction

endpackage

>>> rtl/core/qte_sqrt_stage.sv
`timescale 1ns / 1ps
// One restoring step of the integer square root
module qte_sqrt_stage #(
  parameter int BIT_EXP = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qte_pkg::V_W-1:0]     rem_i,
  input  logic [qte_pkg::V_W-1:0]     root_i,
  output logic [qte_pkg::V_W-1:0]     rem_r,
  output logic [qte_pkg::V_W-1:0]     root_r
);

  localparam logic [qte_pkg::V_W-1:0] BIT = qte_pkg::V_W'(1) << BIT_EXP;

  logic [qte_pkg::V_W-1:0] trial;
  logic [qte_pkg::V_W-1:0] rem_nxt;
  logic [qte_pkg::V_W-1:0] root_nxt;

  // trial subtract
  always_comb begin
    trial = root_i + BIT;
    if (rem_i >= trial) begin
      rem_nxt  = rem_i - trial;
      root_nxt = (root_i >> 1) + BIT;
    end else begin
      rem_nxt  = rem_i;
      root_nxt = root_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

>>> rtl/core/qte_cordic_stage.sv
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation, registered
module qte_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::lane_t   lane_i,
  output qte_pkg::lane_t   lane_r
);

  localparam logic signed [qte_pkg::ANG_W-1:0] ATAN = qte_pkg::atan_deg(SHIFT);

  qte_pkg::lane_t lane_nxt;

  // rotate toward y = 0
  always_comb begin
    lane_nxt = lane_i;
    if (lane_i.y >= 0) begin
      lane_nxt.x   = lane_i.x + (lane_i.y >>> SHIFT);
      lane_nxt.y   = lane_i.y - (lane_i.x >>> SHIFT);
      lane_nxt.ang = lane_i.ang + ATAN;
    end else begin
      lane_nxt.x   = lane_i.x - (lane_i.y >>> SHIFT);
      lane_nxt.y   = lane_i.y + (lane_i.x >>> SHIFT);
      lane_nxt.ang = lane_i.ang - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

>>> rtl/core/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Quaternion (Q1.14) to heading / pitch / bank in degrees (Q8.7). Fully pipelined:
// one quaternion is taken per cycle while the skid entry is empty; the depth of
// the pipeline is set by the 29-step square root for the pitch cosine followed by
// the CORDIC chain shared in form by all three angles. A two-entry output
// (register plus skid) lets input transfers continue while a result waits; the
// pipeline stalls only when both entries are full.
// The lock threshold register resets to 16383 and should be written while idle.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  logic [63:0] in_tdata,
  // to_object [0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // heading_deg [15:0], pitch_deg [30:16], bank_deg [46:31], zero [47]
  output logic [47:0] out_tdata,
  // gimbal_lock [0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [14:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int AW  = qte_pkg::AW;
  localparam int PW  = qte_pkg::PW;
  localparam int CW  = qte_pkg::CW;
  localparam int V_W = qte_pkg::V_W;
  localparam int SQN = qte_pkg::SQ_STAGES;

  logic en;
  logic [14:0] thr_r;

  // lock threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd16383;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // stage 1: capture, conjugate by negating w
  logic               vld1_r;
  logic signed [16:0] w1_r;
  logic signed [15:0] x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= in_tuser ? -17'($signed(in_tdata[15:0])) : 17'($signed(in_tdata[15:0]));
      x1_r <= $signed(in_tdata[31:16]);
      y1_r <= $signed(in_tdata[47:32]);
      z1_r <= $signed(in_tdata[63:48]);
    end
  end

  // stage 2: products
  logic vld2_r;
  logic signed [AW-1:0] wx_r, wy_r, wz_r, xy_r, xz_r, yz_r, xx_r, yy_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= AW'(w1_r) * AW'(x1_r);
      wy_r <= AW'(w1_r) * AW'(y1_r);
      wz_r <= AW'(w1_r) * AW'(z1_r);
      xy_r <= AW'(x1_r) * AW'(y1_r);
      xz_r <= AW'(x1_r) * AW'(z1_r);
      yz_r <= AW'(y1_r) * AW'(z1_r);
      xx_r <= AW'(x1_r) * AW'(x1_r);
      yy_r <= AW'(y1_r) * AW'(y1_r);
      zz_r <= AW'(z1_r) * AW'(z1_r);
    end
  end

  // stage 3: sine of pitch and atan2 arguments of both branches
  logic vld3_r;
  logic signed [PW-1:0] sp3_r;
  logic signed [AW-1:0] hyn3_r, hxn3_r, hyl3_r, hxl3_r, by3_r, bx3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp3_r  <= -(PW'(yz_r) - PW'(wx_r)) <<< 1;
      hyn3_r <= xz_r + wy_r;
      hxn3_r <= qte_pkg::HALF_Q28 - xx_r - yy_r;
      hyl3_r <= wy_r - xz_r;
      hxl3_r <= qte_pkg::HALF_Q28 - yy_r - zz_r;
      by3_r  <= xy_r + wz_r;
      bx3_r  <= qte_pkg::HALF_Q28 - xx_r - zz_r;
    end
  end

  // stage 4: lock decision, branch select, clamp for asin
  logic vld4_r;
  qte_pkg::side_t side4_nxt, side4_r;
  logic [PW-1:0] mag;

  always_comb begin
    mag = (sp3_r < 0) ? PW'(-sp3_r) : PW'(sp3_r);
    side4_nxt.lock   = mag > PW'({thr_r, 14'd0});
    side4_nxt.sp_pos = sp3_r > 0;
    side4_nxt.hy = side4_nxt.lock ? hyl3_r : hyn3_r;
    side4_nxt.hx = side4_nxt.lock ? hxl3_r : hxn3_r;
    side4_nxt.by = by3_r;
    side4_nxt.bx = bx3_r;
    if (sp3_r > qte_pkg::ONE_Q28) begin
      side4_nxt.s = qte_pkg::S_W'(qte_pkg::ONE_Q28);
    end else if (sp3_r < -qte_pkg::ONE_Q28) begin
      side4_nxt.s = qte_pkg::S_W'(-qte_pkg::ONE_Q28);
    end else begin
      side4_nxt.s = sp3_r[qte_pkg::S_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4_nxt;
    end
  end

  // stage 5: square of the sine; stage 6: radicand 1 - s^2
  logic vld5_r, vld6_r;
  qte_pkg::side_t side5_r, side6_r;
  logic [V_W-1:0] sq5_r, rem6_r;
  logic signed [59:0] sq_full;

  assign sq_full = 60'(side4_r.s) * 60'(side4_r.s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side4_r;
      sq5_r   <= sq_full[V_W-1:0];
      side6_r <= side5_r;
      rem6_r  <= qte_pkg::ONE_SQ - sq5_r;
    end
  end

  // square root chain, one root bit per stage
  logic [V_W-1:0] rem_a  [SQN+1];
  logic [V_W-1:0] root_a [SQN+1];
  logic [SQN-1:0] vld_sq_r;
  qte_pkg::side_t side_sq_r [SQN];

  assign rem_a[0]  = rem6_r;
  assign root_a[0] = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    qte_sqrt_stage #(
      .BIT_EXP (2 * (SQN - 1 - k))
    ) u_sqrt (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_a[k]),
      .root_i (root_a[k]),
      .rem_r  (rem_a[k+1]),
      .root_r (root_a[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sq_r <= '0;
    end else if (en) begin
      vld_sq_r <= {vld_sq_r[SQN-2:0], vld6_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq_r[0] <= side6_r;
      for (int k = 1; k < SQN; k++) begin
        side_sq_r[k] <= side_sq_r[k-1];
      end
    end
  end

  // quadrant fold for the three angles
  logic vld_pre_r;
  qte_pkg::lane_t h_a [CORDIC_STAGES+1];
  qte_pkg::lane_t p_a [CORDIC_STAGES+1];
  qte_pkg::lane_t b_a [CORDIC_STAGES+1];
  qte_pkg::side_t side_l;
  logic [V_W-1:0] cos_q28;

  assign side_l  = side_sq_r[SQN-1];
  assign cos_q28 = root_a[SQN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_pre_r <= 1'b0;
    end else if (en) begin
      vld_pre_r <= vld_sq_r[SQN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_a[0] <= qte_pkg::prerot(CW'(side_l.hy), CW'(side_l.hx));
      p_a[0] <= qte_pkg::prerot(CW'(side_l.s), $signed({1'b0, cos_q28[CW-2:0]}));
      b_a[0] <= qte_pkg::prerot(CW'(side_l.by), CW'(side_l.bx));
    end
  end

  // CORDIC stages, three lanes side by side
  logic [CORDIC_STAGES-1:0] vld_co_r, lk_co_r, pp_co_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_stage #(.SHIFT(i)) u_h (
      .clk (clk), .en (en), .lane_i (h_a[i]), .lane_r (h_a[i+1])
    );
    qte_cordic_stage #(.SHIFT(i)) u_p (
      .clk (clk), .en (en), .lane_i (p_a[i]), .lane_r (p_a[i+1])
    );
    qte_cordic_stage #(.SHIFT(i)) u_b (
      .clk (clk), .en (en), .lane_i (b_a[i]), .lane_r (b_a[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_co_r <= '0;
    end else if (en) begin
      vld_co_r <= {vld_co_r[CORDIC_STAGES-2:0], vld_pre_r};
    end
  end

  // lock and pitch sign travel with the lanes; they leave the sqrt chain with the
  // root, so like the lanes they pass through a fold-stage register first
  logic lk_pre_r, pp_pre_r;
  always_ff @(posedge clk) begin
    if (en) begin
      lk_pre_r <= side_l.lock;
      pp_pre_r <= side_l.sp_pos;
      lk_co_r  <= {lk_co_r[CORDIC_STAGES-2:0], lk_pre_r};
      pp_co_r  <= {pp_co_r[CORDIC_STAGES-2:0], pp_pre_r};
    end
  end

  // round, saturate, pick the branch
  logic rnd_v_r, rnd_lock_r;
  logic signed [15:0] rnd_head_r, rnd_bank_r;
  logic signed [14:0] rnd_pitch_r;
  qte_pkg::lane_t hf, pf, bf;
  logic signed [15:0] head_q, pitch_q, bank_q;

  assign hf = h_a[CORDIC_STAGES];
  assign pf = p_a[CORDIC_STAGES];
  assign bf = b_a[CORDIC_STAGES];

  always_comb begin
    head_q  = hf.zero ? '0 : qte_pkg::to_q7(hf.ang, qte_pkg::LIM_180);
    pitch_q = pf.zero ? '0 : qte_pkg::to_q7(pf.ang, qte_pkg::LIM_90);
    bank_q  = bf.zero ? '0 : qte_pkg::to_q7(bf.ang, qte_pkg::LIM_180);
    if (lk_co_r[CORDIC_STAGES-1]) begin
      pitch_q = pp_co_r[CORDIC_STAGES-1] ? qte_pkg::LIM_90 : -qte_pkg::LIM_90;
      bank_q  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else if (en) begin
      rnd_v_r <= vld_co_r[CORDIC_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_head_r  <= head_q;
      rnd_pitch_r <= pitch_q[14:0];
      rnd_bank_r  <= bank_q;
      rnd_lock_r  <= lk_co_r[CORDIC_STAGES-1];
    end
  end

  // output register and skid entry
  logic out_valid_r, skid_v_r;
  logic signed [15:0] out_head_r, out_bank_r, skid_head_r, skid_bank_r;
  logic signed [14:0] out_pitch_r, skid_pitch_r;
  logic out_lock_r, skid_lock_r;
  logic pop, push;

  assign en   = !skid_v_r;
  assign pop  = out_valid_r && out_tready;
  assign push = en && rnd_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_head_r  <= skid_head_r;
        out_pitch_r <= skid_pitch_r;
        out_bank_r  <= skid_bank_r;
        out_lock_r  <= skid_lock_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_head_r  <= rnd_head_r;
        skid_pitch_r <= rnd_pitch_r;
        skid_bank_r  <= rnd_bank_r;
        skid_lock_r  <= rnd_lock_r;
      end else begin
        out_head_r  <= rnd_head_r;
        out_pitch_r <= rnd_pitch_r;
        out_bank_r  <= rnd_bank_r;
        out_lock_r  <= rnd_lock_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_lock_r;
  assign out_tdata  = {1'b0, out_bank_r, out_pitch_r, out_head_r};

`include "quaternion_to_euler_angles_assert.svh"

  `QTE_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_v_r, out_valid_r)
  `QTE_ASSERT_NXT(a_skid_drains, clk, rst_n, skid_v_r && out_tready, !skid_v_r)
  `QTE_ASSERT_IMP(a_lock_bank_zero, clk, rst_n, out_valid_r && out_lock_r, out_bank_r == '0)
  `QTE_ASSERT_IMP(a_lock_pitch, clk, rst_n, out_valid_r && out_lock_r, (out_pitch_r == 15'sd11520) || (out_pitch_r == -15'sd11520))

endmodule
